/* src/dq_pkg.sv */
package dq_pkg;

    localparam int VAL_W  = 32;
    localparam int CMD_W  = 3;
    localparam int ST_W   = 2;
    localparam int ECNT_W = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd4;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_POP_F,
        S_POP_B,
        S_CHK_F,
        S_CHK_B,
        S_SCAN,
        S_SHIFT,
        S_REPLY
    } t_state;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_PUSH_FRONT,
        DP_PUSH_BACK,
        DP_SET_FULL,
        DP_SET_EMPTY,
        DP_SET_MISS,
        DP_RD_FRONT,
        DP_RD_BACK,
        DP_TAKE_FRONT,
        DP_TAKE_BACK,
        DP_SCAN_START,
        DP_SCAN_NEXT,
        DP_HIT,
        DP_HIT_LAST,
        DP_SHIFT,
        DP_SHIFT_LAST,
        DP_REPLY
    } t_dp_op;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             empty;
        logic             full;
        logic             match;
        logic             pos_last;
        logic             shift_last;
        logic             count_one;
        logic             out_busy;
    } t_dp_stat;

endpackage

/* src/dq_ctrl.sv */
module dq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  dq_pkg::t_dp_stat i_stat,
    output dq_pkg::t_dp_op   o_op,
    output logic             o_in_stall
);
    import dq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_stat.cmd)
                    CMD_POP_FRONT: n_state = i_stat.empty ? S_REPLY : S_POP_F;
                    CMD_POP_BACK:  n_state = i_stat.empty ? S_REPLY : S_POP_B;
                    CMD_REMOVE:    n_state = i_stat.empty ? S_REPLY : S_CHK_F;
                    default:       n_state = S_REPLY;
                endcase
            end
            S_POP_F, S_POP_B: n_state = S_REPLY;
            S_CHK_F: n_state = i_stat.match ? S_REPLY : S_CHK_B;
            S_CHK_B: begin
                n_state = (i_stat.match || i_stat.count_one) ? S_REPLY : S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.pos_last) begin
                    n_state = S_REPLY;
                end else begin
                    n_state = i_stat.match ? S_SHIFT : S_SCAN;
                end
            end
            S_SHIFT: n_state = i_stat.shift_last ? S_REPLY : S_SHIFT;
            S_REPLY: begin
                if (!i_stat.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_op       = DP_NOP;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op = DP_LOAD;
                end
            end
            S_EXEC: begin
                case (i_stat.cmd)
                    CMD_PUSH_FRONT: o_op = i_stat.full ? DP_SET_FULL : DP_PUSH_FRONT;
                    CMD_PUSH_BACK:  o_op = i_stat.full ? DP_SET_FULL : DP_PUSH_BACK;
                    CMD_POP_FRONT:  o_op = i_stat.empty ? DP_SET_EMPTY : DP_RD_FRONT;
                    CMD_POP_BACK:   o_op = i_stat.empty ? DP_SET_EMPTY : DP_RD_BACK;
                    CMD_REMOVE:     o_op = i_stat.empty ? DP_SET_EMPTY : DP_RD_FRONT;
                    default:        o_op = DP_NOP;
                endcase
            end
            S_POP_F: o_op = DP_TAKE_FRONT;
            S_POP_B: o_op = DP_TAKE_BACK;
            S_CHK_F: o_op = i_stat.match ? DP_TAKE_FRONT : DP_RD_BACK;
            S_CHK_B: begin
                if (i_stat.match) begin
                    o_op = DP_TAKE_BACK;
                end else begin
                    o_op = i_stat.count_one ? DP_SET_MISS : DP_SCAN_START;
                end
            end
            S_SCAN: begin
                if (i_stat.match) begin
                    o_op = i_stat.pos_last ? DP_HIT_LAST : DP_HIT;
                end else begin
                    o_op = i_stat.pos_last ? DP_SET_MISS : DP_SCAN_NEXT;
                end
            end
            S_SHIFT: o_op = i_stat.shift_last ? DP_SHIFT_LAST : DP_SHIFT;
            S_REPLY: begin
                if (!i_stat.out_busy) begin
                    o_op = DP_REPLY;
                end
            end
            default: o_op = DP_NOP;
        endcase
    end

endmodule

/* src/dq_datapath.sv */
module dq_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dq_pkg::t_dp_op                   i_op,
    output dq_pkg::t_dp_stat                 o_stat,
    input  logic        [dq_pkg::CMD_W-1:0]  i_command,
    input  logic signed [dq_pkg::VAL_W-1:0]  i_value,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output logic signed [dq_pkg::VAL_W-1:0]  o_result_value,
    output logic        [dq_pkg::ST_W-1:0]   o_status,
    output logic        [dq_pkg::ECNT_W-1:0] o_entry_count
);
    import dq_pkg::*;

    localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int SW  = CW + 2;
    localparam int EXW = CW + ECNT_W;

    logic signed [VAL_W-1:0] r_mem [CAPACITY];
    logic signed [VAL_W-1:0] r_rd_data;

    logic        [CMD_W-1:0] r_cmd;
    logic signed [VAL_W-1:0] r_val;
    logic signed [VAL_W-1:0] r_res;
    logic        [ST_W-1:0]  r_status;
    logic        [IW-1:0]    r_front, n_front;
    logic        [CW-1:0]    r_count, n_count;
    logic        [CW-1:0]    r_pos, n_pos;

    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_res;
    logic        [ST_W-1:0]  r_out_status;
    logic        [CW-1:0]    r_out_count;

    logic                    wr_en;
    logic        [IW-1:0]    wr_addr;
    logic signed [VAL_W-1:0] wr_data;
    logic        [IW-1:0]    rd_addr;
    logic        [CW:0]      cnt_x;
    logic        [CW:0]      pos_x;
    logic        [IW-1:0]    front_dec;
    logic        [IW-1:0]    front_inc;
    logic        [EXW-1:0]   cnt_ext;

    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] front,
                                              input logic [CW:0] k);
        logic [SW-1:0] s;
        s = SW'(front) + SW'(k);
        if (s >= SW'(CAPACITY)) begin
            s = s - SW'(CAPACITY);
        end
        return s[IW-1:0];
    endfunction

    assign cnt_x     = {1'b0, r_count};
    assign pos_x     = {1'b0, r_pos};
    assign front_dec = (r_front == '0) ? IW'(CAPACITY - 1) : r_front - IW'(1);
    assign front_inc = (r_front == IW'(CAPACITY - 1)) ? '0 : r_front + IW'(1);

    always_comb begin
        o_stat            = '0;
        o_stat.cmd        = r_cmd;
        o_stat.empty      = (r_count == '0);
        o_stat.full       = (r_count == CW'(CAPACITY));
        o_stat.match      = (r_rd_data == r_val);
        o_stat.pos_last   = (pos_x + (CW+1)'(1) == cnt_x);
        o_stat.shift_last = (pos_x + (CW+1)'(2) == cnt_x);
        o_stat.count_one  = (r_count == CW'(1));
        o_stat.out_busy   = r_out_valid && i_out_stall;
    end

    always_comb begin
        case (i_op)
            DP_RD_BACK:           rd_addr = slot_of(r_front, cnt_x - (CW+1)'(1));
            DP_SCAN_START:        rd_addr = slot_of(r_front, (CW+1)'(1));
            DP_SCAN_NEXT, DP_HIT: rd_addr = slot_of(r_front, pos_x + (CW+1)'(1));
            DP_SHIFT:             rd_addr = slot_of(r_front, pos_x + (CW+1)'(2));
            default:              rd_addr = r_front;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_front;
        wr_data = r_rd_data;
        n_front = r_front;
        n_count = r_count;
        n_pos   = r_pos;
        case (i_op)
            DP_PUSH_FRONT: begin
                wr_en   = 1'b1;
                wr_addr = front_dec;
                wr_data = r_val;
                n_front = front_dec;
                n_count = r_count + CW'(1);
            end
            DP_PUSH_BACK: begin
                wr_en   = 1'b1;
                wr_addr = slot_of(r_front, cnt_x);
                wr_data = r_val;
                n_count = r_count + CW'(1);
            end
            DP_TAKE_FRONT: begin
                n_front = front_inc;
                n_count = r_count - CW'(1);
            end
            DP_TAKE_BACK, DP_HIT_LAST: n_count = r_count - CW'(1);
            DP_SCAN_START:             n_pos   = CW'(1);
            DP_SCAN_NEXT:              n_pos   = r_pos + CW'(1);
            DP_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = slot_of(r_front, pos_x);
                n_pos   = r_pos + CW'(1);
            end
            DP_SHIFT_LAST: begin
                wr_en   = 1'b1;
                wr_addr = slot_of(r_front, pos_x);
                n_count = r_count - CW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
            r_pos   <= n_pos;
            if (i_op == DP_REPLY) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            DP_LOAD: begin
                r_cmd    <= i_command;
                r_val    <= i_value;
                r_res    <= '0;
                r_status <= ST_OK;
            end
            DP_SET_FULL:  r_status <= ST_FULL;
            DP_SET_EMPTY: r_status <= ST_EMPTY;
            DP_SET_MISS:  r_status <= ST_NOT_FOUND;
            DP_TAKE_FRONT, DP_TAKE_BACK, DP_HIT, DP_HIT_LAST: r_res <= r_rd_data;
            DP_REPLY: begin
                r_out_res    <= r_res;
                r_out_status <= r_status;
                r_out_count  <= r_count;
            end
            default: ;
        endcase
    end

    assign cnt_ext        = EXW'(r_out_count);
    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_res;
    assign o_status       = r_out_status;
    assign o_entry_count  = cnt_ext[ECNT_W-1:0];

endmodule

/* src/double_ended_queue.sv */
// Channel   Valid         Stall         Word
// input     i_in_valid    o_in_stall    i_command, i_value
// output    o_out_valid   i_out_stall   o_result_value, o_status, o_entry_count
//
// One word at a time. Push, ops on a full or empty queue, unused codes: EXEC, REPLY;
// pop: EXEC, POP_F or POP_B, REPLY. Remove by value: CHK_F on a front hit, CHK_B too on
// a back hit or one-entry miss, else SCAN, SHIFT; ring memory moves one entry a cycle.
// Reset is synchronous, active low; it empties the queue, memory is not cleared.
// Output is registered: a new word is taken while a result waits on i_out_stall.
module double_ended_queue #(
    parameter int CAPACITY = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic        [dq_pkg::CMD_W-1:0]   i_command,
    input  logic signed [dq_pkg::VAL_W-1:0]   i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [dq_pkg::VAL_W-1:0]   o_result_value,
    output logic        [dq_pkg::ST_W-1:0]    o_status,
    output logic        [dq_pkg::ECNT_W-1:0]  o_entry_count
);
    import dq_pkg::*;

    t_dp_op   op;
    t_dp_stat stat;

    dq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_op       (op),
        .o_in_stall (o_in_stall)
    );

    dq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .o_stat         (stat),
        .i_command      (i_command),
        .i_value        (i_value),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count)
    );

endmodule

/* src/dq_checker.sv */
module dq_checker #(
    parameter int CAPACITY = 16
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic        [dq_pkg::CMD_W-1:0]   i_command,
    input logic signed [dq_pkg::VAL_W-1:0]   i_value,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic signed [dq_pkg::VAL_W-1:0]   o_result_value,
    input logic        [dq_pkg::ST_W-1:0]    o_status,
    input logic        [dq_pkg::ECNT_W-1:0]  o_entry_count
);
    import dq_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_value)
            && $stable(o_status) && $stable(o_entry_count))
        else $error("stalled result word changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word taken before the first finished");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_result_value == '0)
        else $error("failed command returned a value");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |-> o_entry_count == '0)
        else $error("empty status with nonzero count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && CAPACITY < 32 |-> int'(o_entry_count) <= CAPACITY)
        else $error("entry count above capacity");

endmodule

bind double_ended_queue dq_checker #(.CAPACITY(CAPACITY)) u_dq_checker (.*);

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

class deque_scoreboard;
    typedef struct {
        logic signed [dq_pkg::VAL_W-1:0]  value;
        logic        [dq_pkg::ST_W-1:0]   status;
        logic        [dq_pkg::ECNT_W-1:0] count;
    } t_reply;

    int                              depth;
    int                              errors;
    logic signed [dq_pkg::VAL_W-1:0] held[$];
    t_reply                          due[$];

    function new(int cap);
        depth  = cap;
        errors = 0;
    endfunction

    function int pending();
        return due.size();
    endfunction

    // Apply one accepted word to the shadow deque and queue its reply.
    function void note_word(logic [dq_pkg::CMD_W-1:0] cmd,
                            logic signed [dq_pkg::VAL_W-1:0] val);
        t_reply r;
        int     hit;
        int     n_held;
        r.value  = '0;
        r.status = dq_pkg::ST_OK;
        hit      = -1;
        case (cmd)
            dq_pkg::CMD_PUSH_FRONT: begin
                if (held.size() >= depth) r.status = dq_pkg::ST_FULL;
                else held.push_front(val);
            end
            dq_pkg::CMD_PUSH_BACK: begin
                if (held.size() >= depth) r.status = dq_pkg::ST_FULL;
                else held.push_back(val);
            end
            dq_pkg::CMD_POP_FRONT: begin
                if (held.size() == 0) r.status = dq_pkg::ST_EMPTY;
                else r.value = held.pop_front();
            end
            dq_pkg::CMD_POP_BACK: begin
                if (held.size() == 0) r.status = dq_pkg::ST_EMPTY;
                else r.value = held.pop_back();
            end
            dq_pkg::CMD_REMOVE: begin
                // front first, then back, then first match from the second entry
                if (held.size() == 0) begin
                    r.status = dq_pkg::ST_EMPTY;
                end else if (held[0] == val) begin
                    r.value = held.pop_front();
                end else if (held[held.size()-1] == val) begin
                    r.value = held.pop_back();
                end else begin
                    for (int i = 1; i < held.size(); i++)
                        if (hit < 0 && held[i] == val) hit = i;
                    if (hit < 0) begin
                        r.status = dq_pkg::ST_NOT_FOUND;
                    end else begin
                        r.value = held[hit];
                        held.delete(hit);
                    end
                end
            end
            default: ;
        endcase
        n_held  = held.size();
        r.count = n_held[dq_pkg::ECNT_W-1:0];
        due.push_back(r);
    endfunction

    function void check_word(logic signed [dq_pkg::VAL_W-1:0]  value,
                             logic        [dq_pkg::ST_W-1:0]   status,
                             logic        [dq_pkg::ECNT_W-1:0] count);
        t_reply exp;
        if (due.size() == 0) begin
            $error("unexpected word: result_value %0d status %0d entry_count %0d",
                   value, status, count);
            errors++;
            return;
        end
        exp = due.pop_front();
        if (exp.value !== value) begin
            $error("result_value: expected %0d, got %0d", exp.value, value);
            errors++;
        end
        if (exp.status !== status) begin
            $error("status: expected %0d, got %0d", exp.status, status);
            errors++;
        end
        if (exp.count !== count) begin
            $error("entry_count: expected %0d, got %0d", exp.count, count);
            errors++;
        end
    endfunction
endclass

module tb;
    import dq_pkg::*;

    localparam int CAP = 16;
    localparam int N_RANDOM = 600;
    localparam int SEGMENT = 40;
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic        [CMD_W-1:0]  i_command;
    logic signed [VAL_W-1:0]  i_value;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [VAL_W-1:0]  o_result_value;
    logic        [ST_W-1:0]   o_status;
    logic        [ECNT_W-1:0] o_entry_count;

    logic idle_on;
    logic calm;
    int   out_burst = 0;

    deque_scoreboard sb = new(CAP);

    double_ended_queue #(.CAPACITY(CAP)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count)
    );

    always #5 i_clk = ~i_clk;

    // output stall bursts
    always @(posedge i_clk) begin
        if (out_burst != 0) begin
            out_burst   <= out_burst - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on && !calm && $urandom_range(0, 4) == 0) begin
            out_burst   <= $urandom_range(0, 6);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_word(o_result_value, o_status, o_entry_count);
    end

    // Called at a clock edge; returns at the edge that accepts the word.
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] val);
        if (idle_on && !calm && $urandom_range(0, 2) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_value    <= val;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_word(cmd, val);
    endtask

    function automatic logic signed [VAL_W-1:0] rand_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) return $signed($urandom_range(0, 8)) - 4;
        if (pick < 6) begin
            case ($urandom_range(0, 3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return '0;
                default: return -1;
            endcase
        end
        return $urandom;
    endfunction

    initial begin
        logic [CMD_W-1:0]        cmd;
        logic signed [VAL_W-1:0] val;
        int                      mode;
        int                      push_pct;
        int                      r;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_command   = '0;
        i_value     = '0;
        idle_on     = 1'b1;
        calm        = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty cases, spare codes, extremes, remove empty, front, back, scan hit, scan miss
        send_word(CMD_POP_FRONT, VAL_MAX);
        send_word(CMD_POP_BACK, VAL_MIN);
        send_word(CMD_REMOVE, '0);
        send_word(CMD_SPARE_FIRST, -1);
        send_word(CMD_SPARE_FIRST + 3'd1, VAL_MIN);
        send_word(CMD_SPARE_LAST, VAL_MAX);
        send_word(CMD_PUSH_BACK, VAL_MIN);
        send_word(CMD_PUSH_FRONT, VAL_MAX);
        send_word(CMD_PUSH_BACK, '0);
        send_word(CMD_PUSH_FRONT, -1);
        send_word(CMD_PUSH_BACK, 32'sd5);
        send_word(CMD_PUSH_BACK, 32'sd0);
        send_word(CMD_REMOVE, VAL_MIN);
        send_word(CMD_REMOVE, 32'sd0);
        send_word(CMD_REMOVE, -1);
        send_word(CMD_REMOVE, 32'sd5);
        send_word(CMD_REMOVE, 32'sd7);
        send_word(CMD_POP_FRONT, '0);
        send_word(CMD_POP_BACK, '0);
        send_word(CMD_POP_BACK, '0);

        mode = 2;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % SEGMENT == 0) begin
                mode    = $urandom_range(0, 2);
                idle_on <= ($urandom_range(0, 3) != 0);
            end
            if (n == N_RANDOM - 100) calm <= 1'b1;
            push_pct = (mode == 0) ? 70 : (mode == 1) ? 20 : 45;
            r = $urandom_range(0, 99);
            val = rand_value();
            if (r < 3) begin
                cmd = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
            end else if (r < 3 + push_pct) begin
                cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
            end else begin
                case ($urandom_range(0, 3))
                    0: cmd = CMD_POP_FRONT;
                    1: cmd = CMD_POP_BACK;
                    default: cmd = CMD_REMOVE;
                endcase
                if (cmd == CMD_REMOVE && sb.held.size() != 0 && $urandom_range(0, 9) < 7)
                    val = sb.held[$urandom_range(0, sb.held.size() - 1)];
            end
            send_word(cmd, val);
        end
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4 * CAP + 20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

/* sim.f */
src/dq_pkg.sv
src/dq_ctrl.sv
src/dq_datapath.sv
src/double_ended_queue.sv
src/dq_checker.sv
tb/sv/tb.sv
